// ===== sv/ucpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ucpc_pkg;

    localparam int RESULT_W = 31;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CP_LIMIT     = 2'd1;

    typedef enum logic [2:0] {
        RC_80_BF = 3'd0,
        RC_A0_BF = 3'd1,
        RC_80_9F = 3'd2,
        RC_90_BF = 3'd3,
        RC_80_8F = 3'd4
    } t_range_class;

    function automatic logic cont_ok(input logic [7:0] b, input t_range_class cls);
        logic ok;
        ok = 1'b0;
        if (b[7:6] == 2'b10) begin
            case (cls)
                RC_A0_BF: ok = b[5];
                RC_80_9F: ok = !b[5];
                RC_90_BF: ok = b[5] | b[4];
                RC_80_8F: ok = !b[5] & !b[4];
                default:  ok = 1'b1;
            endcase
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

// ===== sv/utf8_code_point_counter.sv =====
// UTF-8 validator and code point counter; with the limit enabled it reports a byte length or cut offset.
// Input channel: one string byte per request on i_data_byte, with i_last_byte
// marking the final byte and i_empty_string standing for a zero-length string.
// A request is taken at a rising edge with i_in_valid high and o_in_stall low.
// Output channel: one result per string (on its last byte or empty mark),
// taken at an edge with o_out_valid high and i_out_stall low.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 limit enable, 1 code point limit); write it only while no string is in flight.
// Throughput is one byte per cycle while o_in_stall is low: the decoder state
// update is a single level of registers fed by shallow logic. The result of a
// string is registered into the output queue when its last byte is taken.
// Results wait in a two-entry output queue. While the receiver stalls, input
// is still taken until the second entry is occupied; o_in_stall is high only
// then. Synchronous reset clears the decoder, the counters, both configuration
// registers and the output queue; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module utf8_code_point_counter #(
    parameter int LENGTH_BITS = 31
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  wire  [7:0]                           i_data_byte,
    input  wire                                  i_last_byte,
    input  wire                                  i_empty_string,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output logic [ucpc_pkg::RESULT_W-1:0]        o_result_value,
    output logic                                 o_invalid_utf8,
    output logic                                 o_limit_reached,
    input  wire                                  i_cfg_we,
    input  wire  [ucpc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [ucpc_pkg::RESULT_W-1:0]        i_cfg_data
);

    localparam int RW = ucpc_pkg::RESULT_W;
    localparam int CW = ucpc_pkg::RESULT_W + 1;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    logic                   r_limit_en;
    logic [RW-1:0]          r_max_len;

    logic [LENGTH_BITS-1:0] r_byte_pos,  n_byte_pos;
    logic [LENGTH_BITS-1:0] r_point_cnt, n_point_cnt;
    logic [1:0]             r_pending,   n_pending;
    ucpc_pkg::t_range_class r_range_cls, n_range_cls;
    logic [LENGTH_BITS-1:0] r_seq_start, n_seq_start;
    logic                   r_err,       n_err;
    logic                   r_cut,       n_cut;
    logic [LENGTH_BITS-1:0] r_cut_off,   n_cut_off;

    logic                   in_acc;
    logic                   cp_done;
    logic                   err_final;
    logic                   push;
    logic [RW-1:0]          res_value;
    logic                   res_inv;
    logic                   res_cut;

    logic                   r_out_valid;
    logic [RW-1:0]          r_out_value;
    logic                   r_out_inv;
    logic                   r_out_cut;
    logic                   r_sk_valid;
    logic [RW-1:0]          r_sk_value;
    logic                   r_sk_inv;
    logic                   r_sk_cut;
    logic                   pop;

    assign in_acc = i_in_valid && !o_in_stall;
    assign pop    = r_out_valid && !i_out_stall;

    assign o_in_stall      = r_sk_valid;
    assign o_out_valid     = r_out_valid;
    assign o_result_value  = r_out_value;
    assign o_invalid_utf8  = r_out_inv;
    assign o_limit_reached = r_out_cut;

    always_comb begin
        n_byte_pos  = r_byte_pos;
        n_point_cnt = r_point_cnt;
        n_pending   = r_pending;
        n_range_cls = r_range_cls;
        n_seq_start = r_seq_start;
        n_err       = r_err;
        n_cut       = r_cut;
        n_cut_off   = r_cut_off;
        cp_done     = 1'b0;
        err_final   = 1'b0;
        push        = 1'b0;
        res_value   = '0;
        res_inv     = 1'b0;
        res_cut     = 1'b0;
        if (in_acc) begin
            if (i_empty_string) begin
                n_byte_pos  = '0;
                n_point_cnt = '0;
                n_pending   = 2'd0;
                n_range_cls = ucpc_pkg::RC_80_BF;
                n_seq_start = '0;
                n_err       = 1'b0;
                n_cut       = 1'b0;
                n_cut_off   = '0;
                push        = 1'b1;
            end else begin
                n_byte_pos = (r_byte_pos == LEN_MAX) ? r_byte_pos : r_byte_pos + 1'b1;
                if (!r_err && !r_cut) begin
                    if (r_pending == 2'd0) begin
                        n_seq_start = r_byte_pos;
                        n_range_cls = ucpc_pkg::RC_80_BF;
                        if (!i_data_byte[7]) begin
                            cp_done = 1'b1;
                        end else if (i_data_byte >= 8'hC2 && i_data_byte <= 8'hDF) begin
                            n_pending = 2'd1;
                        end else if (i_data_byte[7:4] == 4'hE) begin
                            n_pending = 2'd2;
                            if (i_data_byte == 8'hE0) begin
                                n_range_cls = ucpc_pkg::RC_A0_BF;
                            end else if (i_data_byte == 8'hED) begin
                                n_range_cls = ucpc_pkg::RC_80_9F;
                            end
                        end else if (i_data_byte >= 8'hF0 && i_data_byte <= 8'hF4) begin
                            n_pending = 2'd3;
                            if (i_data_byte == 8'hF0) begin
                                n_range_cls = ucpc_pkg::RC_90_BF;
                            end else if (i_data_byte == 8'hF4) begin
                                n_range_cls = ucpc_pkg::RC_80_8F;
                            end
                        end else begin
                            n_err = 1'b1;
                        end
                    end else if (ucpc_pkg::cont_ok(i_data_byte, r_range_cls)) begin
                        n_pending   = r_pending - 2'd1;
                        n_range_cls = ucpc_pkg::RC_80_BF;
                        cp_done     = (r_pending == 2'd1);
                    end else begin
                        n_err = 1'b1;
                    end
                    if (cp_done) begin
                        if (r_limit_en
                                && (CW'(r_point_cnt) + CW'(1) > CW'(r_max_len))) begin
                            n_cut     = 1'b1;
                            n_cut_off = n_seq_start;
                        end else if (r_point_cnt != LEN_MAX) begin
                            n_point_cnt = r_point_cnt + 1'b1;
                        end
                    end
                end
                if (i_last_byte) begin
                    push      = 1'b1;
                    err_final = n_err || (!n_cut && n_pending != 2'd0);
                    res_inv   = err_final;
                    if (!err_final) begin
                        if (r_limit_en) begin
                            res_value = n_cut ? RW'(n_cut_off) : RW'(n_byte_pos);
                            res_cut   = n_cut;
                        end else begin
                            res_value = RW'(n_point_cnt);
                        end
                    end
                    n_byte_pos  = '0;
                    n_point_cnt = '0;
                    n_pending   = 2'd0;
                    n_range_cls = ucpc_pkg::RC_80_BF;
                    n_seq_start = '0;
                    n_err       = 1'b0;
                    n_cut       = 1'b0;
                    n_cut_off   = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_en <= 1'b0;
            r_max_len  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ucpc_pkg::CFG_LIMIT_ENABLE: r_limit_en <= i_cfg_data[0];
                ucpc_pkg::CFG_CP_LIMIT:     r_max_len  <= i_cfg_data;
                default:                    r_limit_en <= r_limit_en;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos  <= '0;
            r_point_cnt <= '0;
            r_pending   <= 2'd0;
            r_range_cls <= ucpc_pkg::RC_80_BF;
            r_seq_start <= '0;
            r_err       <= 1'b0;
            r_cut       <= 1'b0;
            r_cut_off   <= '0;
        end else begin
            r_byte_pos  <= n_byte_pos;
            r_point_cnt <= n_point_cnt;
            r_pending   <= n_pending;
            r_range_cls <= n_range_cls;
            r_seq_start <= n_seq_start;
            r_err       <= n_err;
            r_cut       <= n_cut;
            r_cut_off   <= n_cut_off;
        end
    end

    // Two-entry output queue: the skid entry fills only while the head is stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (!r_out_valid || pop) begin
            if (r_sk_valid) begin
                r_out_valid <= 1'b1;
                r_out_value <= r_sk_value;
                r_out_inv   <= r_sk_inv;
                r_out_cut   <= r_sk_cut;
                r_sk_valid  <= push;
                r_sk_value  <= res_value;
                r_sk_inv    <= res_inv;
                r_sk_cut    <= res_cut;
            end else begin
                r_out_valid <= push;
                r_out_value <= res_value;
                r_out_inv   <= res_inv;
                r_out_cut   <= res_cut;
            end
        end else if (push) begin
            r_sk_valid <= 1'b1;
            r_sk_value <= res_value;
            r_sk_inv   <= res_inv;
            r_sk_cut   <= res_cut;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ucpc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ucpc_checker (
    input wire                                  i_clk,
    input wire                                  i_rst_n,
    input wire                                  i_in_valid,
    input wire                                  o_in_stall,
    input wire                                  i_last_byte,
    input wire                                  i_empty_string,
    input wire                                  o_out_valid,
    input wire                                  i_out_stall,
    input wire [ucpc_pkg::RESULT_W-1:0]         o_result_value,
    input wire                                  o_invalid_utf8,
    input wire                                  o_limit_reached
);

    // The input side may only be held off while a result is already waiting.
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result waiting");

    // After a string ends or is emptied, a result is always waiting in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_last_byte || i_empty_string)) |=> o_out_valid)
        else $error("no result after a closing request");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_invalid_utf8 && o_limit_reached))
        else $error("invalid and cut flags both set");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_invalid_utf8) |-> (o_result_value == '0))
        else $error("invalid result carries a non-zero value");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_result_value)
            && $stable(o_invalid_utf8) && $stable(o_limit_reached)))
        else $error("stalled result changed");

endmodule

bind utf8_code_point_counter ucpc_checker u_ucpc_checker (.*);

`default_nettype wire
